// ===== rtl/olist_pkg.sv =====
// Shared types, codes and command/status bundles for the ordered list engine.
`default_nettype none

package olist_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int POS_W        = 5;
   localparam int VALUE_W      = 32;

   // Request kinds.
   localparam logic [2:0] KIND_INS_FRONT = 3'd0;
   localparam logic [2:0] KIND_INS_BACK  = 3'd1;
   localparam logic [2:0] KIND_INS_AFTER = 3'd2;
   localparam logic [2:0] KIND_DEL_FRONT = 3'd3;
   localparam logic [2:0] KIND_DEL_BACK  = 3'd4;
   localparam logic [2:0] KIND_DEL_AFTER = 3'd5;
   localparam logic [2:0] KIND_COUNT     = 3'd6;
   localparam logic [2:0] KIND_SEARCH    = 3'd7;

   // Result status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_BAD_POS   = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_DELETE,
      OP_DEL_BACK,
      OP_COUNT,
      OP_SEARCH,
      OP_READ
   } olist_op_type;

   typedef struct packed {
      logic [2:0]                kind;
      logic                      read_all;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } olist_req_type;

   typedef struct packed {
      logic [2:0]                status;
      logic signed [VALUE_W-1:0] item_value;
      logic [POS_W-1:0]          item_position;
      logic [POS_W-1:0]          entry_count;
      logic                      last;
   } olist_rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic req_load;   // latch the request word
      logic idx_init;   // start the walk index for this operation
      logic idx_step;   // advance the walk index (down for insert, up otherwise)
      logic mem_rd;     // read the entry the walk points at
      logic wr_shift;   // write the entry just read one place over
      logic wr_new;     // write the new value into the opened gap
      logic fin_load;   // load the single closing result, commit fill
      logic item_load;  // load one read-out result
   } olist_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      olist_op_type op;
      logic         err;
      logic         more;
      logic         match;
      logic         last_item;
      logic         rsp_free;
   } olist_stat_type;

endpackage

`default_nettype wire

// ===== rtl/olist_datapath.sv =====
// Datapath of the ordered list engine: entry memory, fill count, walk index, result register.
`default_nettype none

module olist_datapath #(
   parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  olist_pkg::olist_req_type req_data,
   input  olist_pkg::olist_cmd_type cmd,
   output olist_pkg::olist_stat_type stat,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output olist_pkg::olist_rsp_type rsp_data
);
   import olist_pkg::*;

   localparam int CntW  = $clog2(CAPACITY + 1);
   localparam int AddrW = $clog2(CAPACITY);
   localparam int CmpW  = (CntW > POS_W) ? CntW : POS_W;

   logic signed [VALUE_W-1:0] entry_mem_ff [CAPACITY];
   logic signed [VALUE_W-1:0] rd_data_ff;

   olist_req_type  req_ff;
   olist_rsp_type  rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] idx_plus, idx_minus, at_idx, fill_nxt;
   logic [CmpW-1:0] pos_ext, fill_ext;
   logic            full, empty, found, rsp_free;
   logic [2:0]      err_st, fin_st;
   olist_op_type    op;
   logic [AddrW-1:0] rd_addr, wr_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic            wr_en;

   assign idx_plus  = idx_ff + CntW'(1);
   assign idx_minus = idx_ff - CntW'(1);
   assign pos_ext   = CmpW'(req_ff.position);
   assign fill_ext  = CmpW'(fill_ff);
   assign full      = (fill_ff == CntW'(CAPACITY));
   assign empty     = (fill_ff == '0);
   assign found     = (idx_ff < fill_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Operation class and the error code that the current fill gives it.
   always_comb begin
      op     = OP_COUNT;
      err_st = ST_OK;
      at_idx = '0;
      if (req_ff.read_all) begin
         op = OP_READ;
         if (empty) err_st = ST_EMPTY;
      end else begin
         unique case (req_ff.kind)
            KIND_INS_FRONT: begin
               op = OP_INSERT;
               if (full) err_st = ST_FULL;
            end
            KIND_INS_BACK: begin
               op     = OP_INSERT;
               at_idx = fill_ff;
               if (full) err_st = ST_FULL;
            end
            KIND_INS_AFTER: begin
               op     = OP_INSERT;
               at_idx = CntW'(req_ff.position);
               if (pos_ext == '0 || pos_ext > fill_ext) err_st = ST_BAD_POS;
               else if (full) err_st = ST_FULL;
            end
            KIND_DEL_FRONT: begin
               op = OP_DELETE;
               if (empty) err_st = ST_EMPTY;
            end
            KIND_DEL_BACK: begin
               op = OP_DEL_BACK;
               if (empty) err_st = ST_EMPTY;
            end
            KIND_DEL_AFTER: begin
               op     = OP_DELETE;
               at_idx = CntW'(req_ff.position);
               if (pos_ext == '0 || pos_ext >= fill_ext) err_st = ST_BAD_POS;
            end
            KIND_COUNT: op = OP_COUNT;
            KIND_SEARCH: op = OP_SEARCH;
         endcase
      end
   end

   // Insert walks down from the tail, delete walks up from the gap, scans walk from the front.
   always_comb begin
      stat.op        = op;
      stat.err       = (err_st != ST_OK);
      stat.match     = (rd_data_ff == req_ff.value);
      stat.last_item = (idx_plus == fill_ff);
      stat.rsp_free  = rsp_free;
      case (op)
         OP_INSERT: stat.more = (idx_ff > at_idx);
         OP_DELETE: stat.more = (idx_plus < fill_ff);
         default:   stat.more = found;
      endcase
   end

   always_comb begin
      case (op)
         OP_INSERT: rd_addr = AddrW'(idx_minus);
         OP_DELETE: rd_addr = AddrW'(idx_plus);
         default:   rd_addr = AddrW'(idx_ff);
      endcase
      wr_en   = cmd.wr_shift || cmd.wr_new;
      wr_addr = cmd.wr_new ? AddrW'(at_idx) : AddrW'(idx_ff);
      wr_data = cmd.wr_new ? req_ff.value : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem_ff[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) rd_data_ff <= entry_mem_ff[rd_addr];
   end

   // Fill after a successful operation.
   always_comb begin
      fill_nxt = fill_ff;
      if (err_st == ST_OK) begin
         case (op)
            OP_INSERT:              fill_nxt = fill_ff + CntW'(1);
            OP_DELETE, OP_DEL_BACK: fill_nxt = fill_ff - CntW'(1);
            default:                fill_nxt = fill_ff;
         endcase
      end
   end

   always_comb begin
      fin_st = err_st;
      if (op == OP_SEARCH) fin_st = found ? ST_OK : ST_NOT_FOUND;
   end

   always_comb begin
      fill_in      = cmd.fin_load ? fill_nxt : fill_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.idx_init) begin
         case (op)
            OP_INSERT: idx_in = fill_ff;
            OP_DELETE: idx_in = at_idx;
            default:   idx_in = '0;
         endcase
      end else if (cmd.idx_step) begin
         idx_in = (op == OP_INSERT) ? idx_minus : idx_plus;
      end
      if (cmd.fin_load) begin
         rsp_in.status        = fin_st;
         rsp_in.item_value    = '0;
         rsp_in.item_position = (op == OP_SEARCH && found) ? POS_W'(idx_plus) : '0;
         rsp_in.entry_count   = POS_W'(fill_nxt);
         rsp_in.last          = 1'b1;
         rsp_valid_in         = 1'b1;
      end else if (cmd.item_load) begin
         rsp_in.status        = ST_OK;
         rsp_in.item_value    = rd_data_ff;
         rsp_in.item_position = POS_W'(idx_plus);
         rsp_in.entry_count   = POS_W'(fill_ff);
         rsp_in.last          = stat.last_item;
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         req_ff       <= '0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.req_load) req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/olist_ctrl.sv =====
// Controller of the ordered list engine: sequences decode, entry moves, scans and results.
`default_nettype none

module olist_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  olist_pkg::olist_stat_type stat,
   output olist_pkg::olist_cmd_type  cmd
);
   import olist_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_LOOP,
      S_STEP,
      S_FIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.err || stat.op == OP_COUNT || stat.op == OP_DEL_BACK) begin
               state_in = S_FIN;
            end else begin
               cmd.idx_init = 1'b1;
               state_in     = S_LOOP;
            end
         end
         S_LOOP: begin
            if (stat.more) begin
               cmd.mem_rd = 1'b1;
               state_in   = S_STEP;
            end else begin
               cmd.wr_new = (stat.op == OP_INSERT);
               state_in   = S_FIN;
            end
         end
         S_STEP: begin
            case (stat.op) inside
               OP_INSERT, OP_DELETE: begin
                  cmd.wr_shift = 1'b1;
                  cmd.idx_step = 1'b1;
                  state_in     = S_LOOP;
               end
               OP_SEARCH: begin
                  if (stat.match) begin
                     state_in = S_FIN;
                  end else begin
                     cmd.idx_step = 1'b1;
                     state_in     = S_LOOP;
                  end
               end
               OP_READ: begin
                  // The read data holds until the result register frees up.
                  if (stat.rsp_free) begin
                     cmd.item_load = 1'b1;
                     cmd.idx_step  = 1'b1;
                     state_in      = stat.last_item ? S_IDLE : S_LOOP;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_FIN: begin
            if (stat.rsp_free) begin
               cmd.fin_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ===== rtl/ordered_list_engine_core.sv =====
// Ordered list engine: top level joining the controller and the datapath.
//
// A bounded ordered list of signed 32-bit words held in a CAPACITY-deep memory.
// The req channel takes one request word (insert, delete, count, search or
// read-out); the rsp channel returns its results, a single word with last set,
// or for a read-out one word per element, the final one marked last.
// One request is in service at a time; req_ready is high only when idle.
// Work from acceptance until the closing result is registered:
//   count, delete at the back, or any request that fails its check: decode only
//   other inserts and deletes: one move per element moved (memory has one read
//   and one write port, and each move is a read then a write)
//   search: one compare per element from the front, stopping at a match
//   read-out: one result word per element, from the front
// Results sit in an output register, so the next request is taken while the
// last result still waits. When the receiver stalls, the engine holds its
// work until the result register frees up. Reset empties the list and drops
// any pending result; the entry memory is not cleared.
`default_nettype none

module ordered_list_engine_core #(
   parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  olist_pkg::olist_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output olist_pkg::olist_rsp_type rsp_data
);
   import olist_pkg::*;

   olist_cmd_type  cmd;
   olist_stat_type stat;

   olist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   olist_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another was in service");

   a_fin_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.fin_load |=> req_ready)
      else $error("engine not idle after its closing result");

   a_new_entry_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_new |-> !stat.err && stat.op == OP_INSERT)
      else $error("new entry written for a failed or non-insert request");

   a_item_only_readout: assert property (@(posedge clock) disable iff (reset)
      cmd.item_load |-> stat.op == OP_READ && stat.rsp_free)
      else $error("read-out word loaded outside a read-out");
`endif

endmodule

`default_nettype wire

// ===== tb/ordered_list_engine_core_tb.sv =====
// Self-checking testbench for the ordered list engine: directed and random requests against a list model.
`default_nettype none

module ordered_list_engine_core_tb;
   import olist_pkg::*;

   localparam int CAPACITY      = CAPACITY_DEF;
   localparam int RANDOM_ITEMS  = 410;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PRINT_LIMIT   = 40;

   // Keeps its own copy of the list and the words it must produce.
   class list_scoreboard;
      logic signed [VALUE_W-1:0] contents[$];
      olist_rsp_type             expected[$];
      int                        errors;
      int                        words_seen;

      task report(input string what);
         errors++;
         if (errors <= PRINT_LIMIT)
            $display("MISMATCH at %0t, result word %0d: %s", $time, words_seen, what);
      endtask

      function void expect_word(input logic [2:0] st, input logic signed [VALUE_W-1:0] val,
                                input logic [POS_W-1:0] pos, input logic last);
         olist_rsp_type w;
         w.status        = st;
         w.item_value    = val;
         w.item_position = pos;
         w.entry_count   = POS_W'(contents.size());
         w.last          = last;
         expected.push_back(w);
      endfunction

      function void note_request(input olist_req_type r);
         logic [2:0]       st;
         logic [POS_W-1:0] hit;
         int               fill;
         fill = contents.size();
         st   = ST_OK;
         hit  = '0;
         if (r.read_all) begin
            if (fill == 0)
               expect_word(ST_EMPTY, '0, '0, 1'b1);
            for (int i = 0; i < fill; i++)
               expect_word(ST_OK, contents[i], POS_W'(i + 1), i == fill - 1);
            return;
         end
         case (r.kind)
            KIND_INS_FRONT: begin
               if (fill >= CAPACITY) st = ST_FULL;
               else contents.push_front(r.value);
            end
            KIND_INS_BACK: begin
               if (fill >= CAPACITY) st = ST_FULL;
               else contents.push_back(r.value);
            end
            KIND_INS_AFTER: begin
               // A bad position wins over a full list.
               if (r.position == 0 || r.position > fill) st = ST_BAD_POS;
               else if (fill >= CAPACITY) st = ST_FULL;
               else contents.insert(int'(r.position), r.value);
            end
            KIND_DEL_FRONT: begin
               if (fill == 0) st = ST_EMPTY;
               else void'(contents.pop_front());
            end
            KIND_DEL_BACK: begin
               if (fill == 0) st = ST_EMPTY;
               else void'(contents.pop_back());
            end
            KIND_DEL_AFTER: begin
               if (r.position == 0 || r.position >= fill) st = ST_BAD_POS;
               else contents.delete(int'(r.position));
            end
            KIND_COUNT: ;
            default: begin
               st = ST_NOT_FOUND;
               for (int i = 0; i < fill; i++) begin
                  if (contents[i] == r.value) begin
                     st  = ST_OK;
                     hit = POS_W'(i + 1);
                     break;
                  end
               end
            end
         endcase
         expect_word(st, '0, hit, 1'b1);
      endfunction

      task check_result(input olist_rsp_type got);
         olist_rsp_type want;
         if (expected.size() == 0) begin
            report($sformatf("word with nothing outstanding: %p", got));
         end else begin
            want = expected.pop_front();
            if (got.status !== want.status)
               report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.item_value !== want.item_value)
               report($sformatf("item_value %0d, want %0d", got.item_value, want.item_value));
            if (got.item_position !== want.item_position)
               report($sformatf("item_position %0d, want %0d",
                                got.item_position, want.item_position));
            if (got.entry_count !== want.entry_count)
               report($sformatf("entry_count %0d, want %0d", got.entry_count, want.entry_count));
            if (got.last !== want.last)
               report($sformatf("last %0b, want %0b", got.last, want.last));
         end
         words_seen++;
      endtask
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   olist_req_type req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   olist_rsp_type rsp_data;

   list_scoreboard sb;
   bit             long_hold_due;
   int             cycle_count;

   logic [2:0] insert_kinds[3] = '{KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AFTER};
   logic [2:0] delete_kinds[3] = '{KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_AFTER};

   ordered_list_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_data);
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 25);
   endfunction

   function automatic olist_req_type make_req(input logic [2:0] kind, input logic read_all,
                                              input logic signed [VALUE_W-1:0] value,
                                              input logic [POS_W-1:0] position);
      olist_req_type r;
      r.kind     = kind;
      r.read_all = read_all;
      r.value    = value;
      r.position = position;
      return r;
   endfunction

   // Small values repeat often, so searches meet duplicates.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return VALUE_W'($urandom_range(0, 7));
         1: return -VALUE_W'($urandom_range(1, 4));
         default: return $urandom;
      endcase
   endfunction

   function automatic olist_req_type random_request(input bit growing);
      olist_req_type r;
      int            fill;
      int            roll;
      fill       = sb.contents.size();
      r.read_all = 1'b0;
      r.value    = pick_value();
      r.kind     = 3'($urandom_range(0, 7));
      if (fill > 0 && $urandom_range(0, 4) != 0)
         r.position = POS_W'($urandom_range(1, fill));
      else
         r.position = POS_W'($urandom_range(0, 31));
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         r.read_all = 1'b1;
      end else if (roll < 14) begin
         r.kind = KIND_COUNT;
      end else if (roll < 26) begin
         r.kind = KIND_SEARCH;
         if (fill > 0 && $urandom_range(0, 9) < 7)
            r.value = sb.contents[$urandom_range(0, fill - 1)];
      end else if (($urandom_range(0, 9) < 8) == growing) begin
         r.kind = insert_kinds[$urandom_range(0, 2)];
      end else begin
         r.kind = delete_kinds[$urandom_range(0, 2)];
      end
      return r;
   endfunction

   // Valid is only lowered when a gap follows, so back-to-back words keep it high.
   task automatic send_request(input olist_req_type r, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic run_directed();
      send_request(make_req(KIND_COUNT, 1'b1, 0, 0), pick_gap());
      send_request(make_req(KIND_DEL_FRONT, 1'b0, 0, 0), pick_gap());
      send_request(make_req(KIND_DEL_BACK, 1'b0, 0, 0), pick_gap());
      send_request(make_req(KIND_DEL_AFTER, 1'b0, 0, 1), pick_gap());
      send_request(make_req(KIND_INS_AFTER, 1'b0, 9, 1), pick_gap());
      send_request(make_req(KIND_SEARCH, 1'b0, 0, 0), pick_gap());
      send_request(make_req(KIND_COUNT, 1'b0, 0, 0), pick_gap());
      send_request(make_req(KIND_INS_FRONT, 1'b0, 32'sh8000_0000, 0), pick_gap());
      send_request(make_req(KIND_INS_BACK, 1'b0, 32'sh7fff_ffff, 31), pick_gap());
      send_request(make_req(KIND_INS_AFTER, 1'b0, 3, 0), pick_gap());
      send_request(make_req(KIND_INS_AFTER, 1'b0, 3, 3), pick_gap());
      send_request(make_req(KIND_INS_AFTER, 1'b0, 0, 2), pick_gap());
      send_request(make_req(KIND_INS_AFTER, 1'b0, -1, 1), pick_gap());
      send_request(make_req(KIND_SEARCH, 1'b0, 32'sh7fff_ffff, 0), pick_gap());
      send_request(make_req(KIND_SEARCH, 1'b0, 12345, 0), pick_gap());
      send_request(make_req(KIND_DEL_AFTER, 1'b0, 0, 4), pick_gap());
      send_request(make_req(KIND_DEL_AFTER, 1'b0, 0, 31), pick_gap());
      send_request(make_req(KIND_DEL_AFTER, 1'b0, 0, 1), pick_gap());
      send_request(make_req(KIND_SEARCH, 1'b1, 0, 0), pick_gap());
      // A read-out request wins over the insert its kind field names.
      send_request(make_req(KIND_INS_FRONT, 1'b1, 77, 1), pick_gap());
      send_request(make_req(KIND_COUNT, 1'b0, 0, 0), pick_gap());
      send_request(make_req(KIND_DEL_FRONT, 1'b0, 0, 0), pick_gap());
      send_request(make_req(KIND_DEL_BACK, 1'b0, 0, 0), pick_gap());
   endtask

   // Result side: random stalls, occasional long runs of ready, and one long hold-off.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 80 : 6)) @(posedge clock);
      end
   end

   initial begin
      bit growing;
      sb            = new();
      cycle_count   = 0;
      long_hold_due = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Alternate filling and draining phases so the full and empty cases recur.
      growing = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i > 0 && i % 50 == 0)
            growing = !growing;
         if (i == 120)
            long_hold_due = 1'b1;
         send_request(random_request(growing), (i >= 300 && i < 340) ? 0 : pick_gap());
      end
      req_valid <= 1'b0;

      while (sb.expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.expected.size() != 0)
         sb.report($sformatf("%0d result words never arrived", sb.expected.size()));
      if (sb.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
